// ----- src/sbm_pkg.sv -----
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared types, constants and helpers for the spectrum bar meter with peak
// hold: beat layouts, register indexes, action codes and scale factors.
// ----------------------------------------------------------------------------
package sbm_pkg;

   // Geometry of the meter
   localparam int CHANNELS   = 2;
   localparam int BANDS      = 10;
   localparam int MAX_HEIGHT = 5;

   // Field and datapath widths
   localparam int MAG_W    = 16;
   localparam int LEVEL_W  = 17;
   localparam int HEIGHT_W = 3;
   localparam int BAND_W   = 4;
   localparam int ADDR_W   = 1 + BAND_W;
   localparam int DEPTH    = 2 ** ADDR_W;
   localparam int ENTRY_W  = LEVEL_W + HEIGHT_W;
   localparam int NUM_W    = LEVEL_W + 4;
   localparam int COEF_W   = 27;
   localparam int SCALE_SHIFT = 26;

   // Action codes
   localparam logic [1:0] ACT_BAND        = 2'd0;
   localparam logic [1:0] ACT_PEAK_DECAY  = 2'd1;
   localparam logic [1:0] ACT_RANGE_DECAY = 2'd2;

   // Register indexes
   localparam logic [2:0] REG_GATE_LOW         = 3'd0;
   localparam logic [2:0] REG_GATE_HIGH        = 3'd1;
   localparam logic [2:0] REG_MAP_FLOOR        = 3'd2;
   localparam logic [2:0] REG_RANGE_STEP_UP    = 3'd3;
   localparam logic [2:0] REG_RANGE_STEP_DOWN  = 3'd4;
   localparam logic [2:0] REG_RANGE_DECAY_FLOOR = 3'd5;
   localparam logic [2:0] REG_RANGE_INITIAL    = 3'd6;

   // Register reset values
   localparam logic [MAG_W-1:0] RST_GATE_LOW          = 16'd100;
   localparam logic [MAG_W-1:0] RST_GATE_HIGH         = 16'd10000;
   localparam logic [MAG_W-1:0] RST_MAP_FLOOR         = 16'd120;
   localparam logic [MAG_W-1:0] RST_RANGE_STEP_UP     = 16'd35;
   localparam logic [MAG_W-1:0] RST_RANGE_STEP_DOWN   = 16'd100;
   localparam logic [MAG_W-1:0] RST_RANGE_DECAY_FLOOR = 16'd1300;
   localparam logic [MAG_W-1:0] RST_RANGE_INITIAL     = 16'd2000;

   // Band 0 loses this much before anything else
   localparam logic [MAG_W-1:0] BAND0_OFFSET = 16'd60;

   // Scale factors as multiply-and-shift by 2^26, exact for 16-bit inputs:
   // floor(x*9/10) = (x * 9*ceil(2^26/10)) >> 26
   // floor(x*27/25) = (x * 27*ceil(2^26/25)) >> 26
   localparam logic [COEF_W-1:0] COEF_LOW   = 27'd60397983;
   localparam logic [COEF_W-1:0] COEF_HIGH  = 27'd72477585;
   localparam logic [COEF_W-1:0] COEF_UNITY = 27'd67108864;

   typedef struct packed {
      logic [1:0]        action;
      logic              channel;
      logic [BAND_W-1:0] band;
      logic [MAG_W-1:0]  magnitude;
   } req_type;

   typedef struct packed {
      logic [HEIGHT_W-1:0] bar_height;
      logic [HEIGHT_W-1:0] peak_height;
      logic [MAG_W-1:0]    full_scale_now;
   } rsp_type;

   typedef struct packed {
      logic [MAG_W-1:0] gate_low;
      logic [MAG_W-1:0] gate_high;
      logic [MAG_W-1:0] map_floor;
      logic [MAG_W-1:0] range_step_up;
      logic [MAG_W-1:0] range_step_down;
      logic [MAG_W-1:0] range_decay_floor;
      logic [MAG_W-1:0] range_initial;
   } cfg_type;

   // Full scale load request from a write of range_initial
   typedef struct packed {
      logic             load;
      logic [MAG_W-1:0] value;
   } scale_load_type;

   // Per-band scale coefficient
   function automatic logic [COEF_W-1:0] scale_coef(input logic [BAND_W-1:0] band);
      logic [COEF_W-1:0] coef;
      case (band) inside
         4'd0, 4'd1:   coef = COEF_LOW;
         [4'd7:4'd9]:  coef = COEF_HIGH;
         default:      coef = COEF_UNITY;
      endcase
      return coef;
   endfunction

endpackage

// ----- src/sbm_csr.sv -----
// ----------------------------------------------------------------------------
// sbm_csr
// Configuration registers. Takes one write beat per cycle and flags writes
// of range_initial so the full scale can be reloaded.
// ----------------------------------------------------------------------------
module sbm_csr (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [2:0]               csr_index,
   input  logic [sbm_pkg::MAG_W-1:0] csr_data,
   output sbm_pkg::cfg_type         cfg,
   output sbm_pkg::scale_load_type  scale_load
);

   sbm_pkg::cfg_type cfg_ff;
   sbm_pkg::cfg_type cfg_in;
   logic             wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid & csr_ready;

   // Register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (csr_index)
            sbm_pkg::REG_GATE_LOW:          cfg_in.gate_low          = csr_data;
            sbm_pkg::REG_GATE_HIGH:         cfg_in.gate_high         = csr_data;
            sbm_pkg::REG_MAP_FLOOR:         cfg_in.map_floor         = csr_data;
            sbm_pkg::REG_RANGE_STEP_UP:     cfg_in.range_step_up     = csr_data;
            sbm_pkg::REG_RANGE_STEP_DOWN:   cfg_in.range_step_down   = csr_data;
            sbm_pkg::REG_RANGE_DECAY_FLOOR: cfg_in.range_decay_floor = csr_data;
            sbm_pkg::REG_RANGE_INITIAL:     cfg_in.range_initial     = csr_data;
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gate_low          <= sbm_pkg::RST_GATE_LOW;
         cfg_ff.gate_high         <= sbm_pkg::RST_GATE_HIGH;
         cfg_ff.map_floor         <= sbm_pkg::RST_MAP_FLOOR;
         cfg_ff.range_step_up     <= sbm_pkg::RST_RANGE_STEP_UP;
         cfg_ff.range_step_down   <= sbm_pkg::RST_RANGE_STEP_DOWN;
         cfg_ff.range_decay_floor <= sbm_pkg::RST_RANGE_DECAY_FLOOR;
         cfg_ff.range_initial     <= sbm_pkg::RST_RANGE_INITIAL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg              = cfg_ff;
   assign scale_load.load  = wr && (csr_index == sbm_pkg::REG_RANGE_INITIAL);
   assign scale_load.value = csr_data;

endmodule

// ----- src/sbm_height.sv -----
// ----------------------------------------------------------------------------
// sbm_height
// Bar height unit: floor(num / den) clamped to MAX_HEIGHT, found by adding
// den once per cycle and comparing against num.
// ----------------------------------------------------------------------------
module sbm_height (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [sbm_pkg::NUM_W-1:0]    num,
   input  logic [sbm_pkg::MAG_W-1:0]    den,
   output logic                         done,
   output logic [sbm_pkg::HEIGHT_W-1:0] height
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [sbm_pkg::HEIGHT_W-1:0] k_ff, k_in;
   logic [sbm_pkg::NUM_W-1:0]    acc_ff, acc_in;
   logic [sbm_pkg::NUM_W-1:0]    num_ff, num_in;
   logic [sbm_pkg::MAG_W-1:0]    den_ff, den_in;

   // One multiple of den per cycle; stop at the cap or once past num
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      k_in    = k_ff;
      acc_in  = acc_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         k_in    = '0;
         acc_in  = sbm_pkg::NUM_W'(den);
         num_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         if (k_ff == sbm_pkg::HEIGHT_W'(sbm_pkg::MAX_HEIGHT) || acc_ff > num_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            k_in   = k_ff + 1'b1;
            acc_in = acc_ff + sbm_pkg::NUM_W'(den_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      k_ff   <= k_in;
      acc_ff <= acc_in;
      num_ff <= num_in;
      den_ff <= den_in;
   end

   assign done   = done_ff;
   assign height = k_ff;

endmodule

// ----- src/spectrum_bar_meter_peak_hold.sv -----
// ----------------------------------------------------------------------------
// spectrum_bar_meter_peak_hold
// Stereo spectrum bar meter: per-band level smoothing, noise gate, band
// scaling, shared auto-ranging full scale, bar mapping and peak hold.
//
//   port group  dir   beat                     accepted when
//   req_*       in    req_type (action..mag)   req_valid & req_ready
//   rsp_*       out   rsp_type (bar, peak, fs) rsp_valid & rsp_ready
//   csr_*       in    index + 16-bit data      csr_valid & csr_ready
//
// Band beat: LOAD, SCALE, RANGE, MAP and WRITE when the floor test gives
// bar zero, else LOAD, SCALE, RANGE, MAP, HEIGHT and WRITE: the height unit
// adds one per step. Peak decay tick: one step per level memory entry over
// 32 entries. Range decay tick: done in IDLE. Ticks and ignored beats give
// no response. Reset clears all levels and peaks at once through per-entry
// valid bits. A finished response waits in an output register; req_ready
// stays high while it waits, and only a new band result stalls on rsp_ready.
// ----------------------------------------------------------------------------
module spectrum_bar_meter_peak_hold (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  sbm_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output sbm_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [2:0]                csr_index,
   input  logic [sbm_pkg::MAG_W-1:0] csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCALE,
      ST_RANGE,
      ST_MAP,
      ST_HEIGHT,
      ST_WRITE,
      ST_DECAY_RD
   } state_type;

   localparam int PROD_W = sbm_pkg::MAG_W + sbm_pkg::COEF_W;

   sbm_pkg::cfg_type        cfg;
   sbm_pkg::scale_load_type scale_load;

   state_type                       state_ff, state_in;
   logic                            decay_wr_ff, decay_wr_in;
   sbm_pkg::req_type                item_ff, item_in;
   logic [sbm_pkg::ADDR_W-1:0]      sweep_ff, sweep_in;
   logic [sbm_pkg::HEIGHT_W-1:0]    peak_ff, peak_in;
   logic [sbm_pkg::LEVEL_W-1:0]     prevl_ff, prevl_in;
   logic [sbm_pkg::MAG_W-1:0]       xg_ff, xg_in;
   logic [sbm_pkg::COEF_W-1:0]      coef_ff, coef_in;
   logic [sbm_pkg::LEVEL_W-1:0]     level_ff, level_in;
   logic [sbm_pkg::MAG_W-1:0]       fs_ff, fs_in;
   logic [sbm_pkg::HEIGHT_W-1:0]    bar_ff, bar_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   sbm_pkg::rsp_type                rsp_data_ff, rsp_data_in;
   logic [sbm_pkg::DEPTH-1:0]       valid_ff, valid_in;
   logic                            rd_valid_ff;
   logic [sbm_pkg::ENTRY_W-1:0]     rd_ff;

   // Level memory: {previous level, held peak} per channel and band
   logic [sbm_pkg::ENTRY_W-1:0] mem [sbm_pkg::DEPTH];
   logic [sbm_pkg::ADDR_W-1:0]  mem_raddr;
   logic                        mem_we;
   logic [sbm_pkg::ADDR_W-1:0]  mem_waddr;
   logic [sbm_pkg::ENTRY_W-1:0] mem_wdata;

   logic                          hgt_start;
   logic [sbm_pkg::NUM_W-1:0]     hgt_num;
   logic [sbm_pkg::MAG_W-1:0]     hgt_den;
   logic                          hgt_done;
   logic [sbm_pkg::HEIGHT_W-1:0]  hgt_height;

   logic                          req_fire;
   logic                          in_range;
   logic [sbm_pkg::LEVEL_W-1:0]   rd_level;
   logic [sbm_pkg::HEIGHT_W-1:0]  rd_peak;
   logic [sbm_pkg::MAG_W-1:0]     x0;
   logic [sbm_pkg::LEVEL_W-1:0]   xs;
   logic [PROD_W-1:0]             prod;
   logic [sbm_pkg::LEVEL_W-1:0]   fs_sum;
   logic [sbm_pkg::LEVEL_W-1:0]   level_span;
   logic [sbm_pkg::HEIGHT_W-1:0]  new_peak;

   sbm_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cfg        (cfg),
      .scale_load (scale_load)
   );

   sbm_height u_height (
      .clock  (clock),
      .reset  (reset),
      .start  (hgt_start),
      .num    (hgt_num),
      .den    (hgt_den),
      .done   (hgt_done),
      .height (hgt_height)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign in_range  = (int'(req_data.channel) < sbm_pkg::CHANNELS) &&
                      (int'(req_data.band) < sbm_pkg::BANDS);

   // Entry read back; an entry never written reads as zero
   assign rd_level = rd_valid_ff ? rd_ff[sbm_pkg::ENTRY_W-1 -: sbm_pkg::LEVEL_W] : '0;
   assign rd_peak  = rd_valid_ff ? rd_ff[sbm_pkg::HEIGHT_W-1:0] : '0;

   // Band 0 offset, then add the previous level on a rise
   assign x0 = (item_ff.band == '0) ?
               ((item_ff.magnitude > sbm_pkg::BAND0_OFFSET) ?
                item_ff.magnitude - sbm_pkg::BAND0_OFFSET : '0) :
               item_ff.magnitude;
   assign xs = ({1'b0, x0} > rd_level) ? {1'b0, x0} + rd_level : {1'b0, x0};

   assign prod       = PROD_W'(xg_ff) * PROD_W'(coef_ff);
   assign fs_sum     = {1'b0, fs_ff} + {1'b0, cfg.range_step_up};
   assign level_span = level_ff - {1'b0, cfg.map_floor};
   assign new_peak   = (peak_ff <= bar_ff) ? bar_ff : peak_ff;

   assign hgt_num = sbm_pkg::NUM_W'(level_span) * sbm_pkg::NUM_W'(sbm_pkg::MAX_HEIGHT);
   assign hgt_den = fs_ff - cfg.map_floor;

   assign mem_raddr = (state_ff == ST_IDLE) ? {req_data.channel, req_data.band} : sweep_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      decay_wr_in  = 1'b0;
      item_in      = item_ff;
      sweep_in     = sweep_ff;
      peak_in      = peak_ff;
      prevl_in     = prevl_ff;
      xg_in        = xg_ff;
      coef_in      = coef_ff;
      level_in     = level_ff;
      fs_in        = fs_ff;
      bar_in       = bar_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      valid_in     = valid_ff;
      hgt_start    = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = {item_ff.channel, item_ff.band};
      mem_wdata    = {level_ff, new_peak};

      // Peak decay write-back, one entry behind the read
      if (decay_wr_ff) begin
         mem_waddr = sweep_ff - 1'b1;
         mem_wdata = {rd_level, rd_peak - 1'b1};
         mem_we    = rd_valid_ff && (rd_peak != '0);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               item_in = req_data;
               unique case (req_data.action)
                  sbm_pkg::ACT_BAND: begin
                     if (in_range) begin
                        state_in = ST_LOAD;
                     end
                  end
                  sbm_pkg::ACT_PEAK_DECAY: begin
                     sweep_in = '0;
                     state_in = ST_DECAY_RD;
                  end
                  sbm_pkg::ACT_RANGE_DECAY: begin
                     if (fs_ff >= cfg.range_decay_floor) begin
                        fs_in = (fs_ff >= cfg.range_step_down) ?
                                fs_ff - cfg.range_step_down : '0;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOAD: begin
            peak_in  = rd_peak;
            prevl_in = rd_level;
            coef_in  = sbm_pkg::scale_coef(item_ff.band);
            xg_in    = (xs > {1'b0, cfg.gate_low} && xs < {1'b0, cfg.gate_high}) ?
                       xs[sbm_pkg::MAG_W-1:0] : '0;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            level_in = prod[sbm_pkg::SCALE_SHIFT +: sbm_pkg::LEVEL_W];
            state_in = ST_RANGE;
         end
         ST_RANGE: begin
            if (level_ff >= {1'b0, fs_ff}) begin
               fs_in = fs_sum[sbm_pkg::MAG_W] ? '1 : fs_sum[sbm_pkg::MAG_W-1:0];
            end
            state_in = ST_MAP;
         end
         ST_MAP: begin
            if (fs_ff <= cfg.map_floor || level_ff <= {1'b0, cfg.map_floor}) begin
               bar_in   = '0;
               state_in = ST_WRITE;
            end else begin
               hgt_start = 1'b1;
               state_in  = ST_HEIGHT;
            end
         end
         ST_HEIGHT: begin
            if (hgt_done) begin
               bar_in   = hgt_height;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               mem_we                     = 1'b1;
               valid_in[mem_waddr]        = 1'b1;
               rsp_valid_in               = 1'b1;
               rsp_data_in.bar_height     = bar_ff;
               rsp_data_in.peak_height    = new_peak;
               rsp_data_in.full_scale_now = fs_ff;
               state_in                   = ST_IDLE;
            end
         end
         ST_DECAY_RD: begin
            decay_wr_in = 1'b1;
            sweep_in    = sweep_ff + 1'b1;
            if (sweep_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // A write of range_initial reloads the full scale
      if (scale_load.load) begin
         fs_in = scale_load.value;
      end
   end

   // Sweep reads every cycle; ST_DECAY_RD loops on itself with the
   // write-back of the previous entry overlapping the next read.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         decay_wr_ff  <= 1'b0;
         fs_ff        <= sbm_pkg::RST_RANGE_INITIAL;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         decay_wr_ff  <= decay_wr_in;
         fs_ff        <= fs_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
      end
      item_ff     <= item_in;
      sweep_ff    <= sweep_in;
      peak_ff     <= peak_in;
      prevl_ff    <= prevl_in;
      xg_ff       <= xg_in;
      coef_ff     <= coef_in;
      level_ff    <= level_in;
      bar_ff      <= bar_in;
      rsp_data_ff <= rsp_data_in;
      rd_valid_ff <= valid_ff[mem_raddr];
   end

   // Level memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[mem_raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   a_bar_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.bar_height <= sbm_pkg::HEIGHT_W'(sbm_pkg::MAX_HEIGHT))
      else $error("bar height above maximum");

   a_peak_ge_bar: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.peak_height >= rsp_data.bar_height)
      else $error("held peak below bar");

   a_write_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE && mem_we) |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("band write without response");

   a_scale_rises: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RANGE && level_ff >= {1'b0, fs_ff} && !scale_load.load)
      |=> fs_ff >= $past(fs_ff))
      else $error("full scale fell on a rise");

   a_prev_used: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCALE) |-> prevl_ff <= {1'b0, {sbm_pkg::MAG_W{1'b1}}} || xg_ff == '0
      || prevl_ff != '0)
      else $error("previous level tracking broken");

endmodule
